// File: rtl/assert_macros.svh
// Assertion macros shared by the register-file RTL.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression that must never be true outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// File: rtl/psgrf_pkg.sv
// Shared types and constants of the sound generator register file.
// No dependencies.
package psgrf_pkg;

    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 8;
    localparam int CHSEL_W   = 3;
    localparam int SAMPLE_W  = 5;
    localparam int FREQ_HI_W = 4;

    // Register numbers
    localparam logic [ADDR_W-1:0] REG_CHSEL    = 4'd0;
    localparam logic [ADDR_W-1:0] REG_VOLUME   = 4'd1;
    localparam logic [ADDR_W-1:0] REG_FREQ_LO  = 4'd2;
    localparam logic [ADDR_W-1:0] REG_FREQ_HI  = 4'd3;
    localparam logic [ADDR_W-1:0] REG_CONTROL  = 4'd4;
    localparam logic [ADDR_W-1:0] REG_BALANCE  = 4'd5;
    localparam logic [ADDR_W-1:0] REG_WAVE     = 4'd6;
    localparam logic [ADDR_W-1:0] REG_NOISE    = 4'd7;
    localparam logic [ADDR_W-1:0] REG_LFO_FREQ = 4'd8;
    localparam logic [ADDR_W-1:0] REG_LFO_CTRL = 4'd9;

    localparam logic [DATA_W-1:0] CTRL_RESET      = 8'h80;
    localparam int                CTRL_DIRECT_BIT = 6;

    // Commands from controller to datapath
    typedef struct packed {
        logic wr;   // perform a register write this cycle
        logic rd;   // capture read data this cycle
    } cmd_t;

endpackage

// File: rtl/psgrf_ctrl.sv
// Access controller: accepts items and sequences the read response strobe.
// Depends on psgrf_pkg.
module psgrf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            req_type,
    output psgrf_pkg::cmd_t cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.wr = accept && req_type;
        cmd.rd = accept && !req_type;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.rd)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next == ST_RESP);
            done_reg  <= (state_next == ST_RESP);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: rtl/psgrf_datapath.sv
// Register file datapath: global and per-channel registers, wave RAM, read mux.
// Depends on psgrf_pkg; driven by psgrf_ctrl commands.
module psgrf_datapath #(
    parameter int NUM_CHANNELS  = 6,
    parameter int WAVE_DEPTH    = 32,
    parameter int NO_DATA_VALUE = 255
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  psgrf_pkg::cmd_t                  cmd,
    input  logic [psgrf_pkg::ADDR_W-1:0]     reg_addr,
    input  logic [psgrf_pkg::DATA_W-1:0]     write_data,
    output logic [psgrf_pkg::DATA_W-1:0]     read_data
);

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int IDX_W = $clog2(WAVE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WAVE_DEPTH - 1);
    localparam logic [psgrf_pkg::CHSEL_W-1:0] CH_COUNT =
        psgrf_pkg::CHSEL_W'(NUM_CHANNELS);
    localparam logic [psgrf_pkg::DATA_W-1:0] NO_DATA =
        psgrf_pkg::DATA_W'(NO_DATA_VALUE);

    logic [psgrf_pkg::CHSEL_W-1:0]   chsel_reg;
    logic [psgrf_pkg::DATA_W-1:0]    volume_reg;
    logic [psgrf_pkg::DATA_W-1:0]    lfo_freq_reg;
    logic [psgrf_pkg::DATA_W-1:0]    lfo_ctrl_reg;
    logic [psgrf_pkg::DATA_W-1:0]    freq_lo_reg [NUM_CHANNELS];
    logic [psgrf_pkg::FREQ_HI_W-1:0] freq_hi_reg [NUM_CHANNELS];
    logic [psgrf_pkg::DATA_W-1:0]    ctrl_reg    [NUM_CHANNELS];
    logic [psgrf_pkg::DATA_W-1:0]    balance_reg [NUM_CHANNELS];
    logic [psgrf_pkg::DATA_W-1:0]    noise_reg   [NUM_CHANNELS];
    logic [IDX_W-1:0]                idx_reg     [NUM_CHANNELS];
    logic [WAVE_DEPTH-1:0]           wave_vld_reg [NUM_CHANNELS];

    logic [psgrf_pkg::SAMPLE_W-1:0]  wave_mem [NUM_CHANNELS][WAVE_DEPTH];
    logic [psgrf_pkg::SAMPLE_W-1:0]  wave_rd_reg;
    logic                            wave_hit_reg;
    logic                            sel_wave_reg;
    logic [psgrf_pkg::DATA_W-1:0]    rd_mux_reg;

    logic                            ch_ok;
    logic [CH_W-1:0]                 ch;
    logic [IDX_W-1:0]                cur_idx;
    logic [IDX_W-1:0]                idx_next;
    logic [IDX_W-1:0]                wr_idx;
    logic                            direct;
    logic                            wave_we;
    logic [psgrf_pkg::DATA_W-1:0]    rd_value;

    assign ch_ok = (chsel_reg < CH_COUNT);
    // out-of-range channel is clamped so array indexes stay legal
    assign ch    = ch_ok ? chsel_reg[CH_W-1:0] : '0;

    assign cur_idx  = idx_reg[ch];
    assign idx_next = (cur_idx == IDX_LAST) ? '0 : cur_idx + 1'b1;
    assign direct   = ctrl_reg[ch][psgrf_pkg::CTRL_DIRECT_BIT];
    assign wr_idx   = direct ? '0 : cur_idx;
    assign wave_we  = cmd.wr && ch_ok && (reg_addr == psgrf_pkg::REG_WAVE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chsel_reg    <= '0;
            volume_reg   <= '0;
            lfo_freq_reg <= '0;
            lfo_ctrl_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                freq_lo_reg[i]  <= '0;
                freq_hi_reg[i]  <= '0;
                ctrl_reg[i]     <= psgrf_pkg::CTRL_RESET;
                balance_reg[i]  <= '0;
                noise_reg[i]    <= '0;
                idx_reg[i]      <= '0;
                wave_vld_reg[i] <= '0;
            end
        end
        else if (cmd.wr)
        begin
            if (reg_addr == psgrf_pkg::REG_CHSEL)
            begin
                chsel_reg <= write_data[psgrf_pkg::CHSEL_W-1:0];
            end
            else if (ch_ok)
            begin
                case (reg_addr)
                    psgrf_pkg::REG_VOLUME:   volume_reg      <= write_data;
                    psgrf_pkg::REG_FREQ_LO:  freq_lo_reg[ch] <= write_data;
                    psgrf_pkg::REG_FREQ_HI:
                        freq_hi_reg[ch] <= write_data[psgrf_pkg::FREQ_HI_W-1:0];
                    psgrf_pkg::REG_CONTROL:  ctrl_reg[ch]    <= write_data;
                    psgrf_pkg::REG_BALANCE:  balance_reg[ch] <= write_data;
                    psgrf_pkg::REG_WAVE:
                    begin
                        wave_vld_reg[ch][wr_idx] <= 1'b1;
                        if (!direct)
                        begin
                            idx_reg[ch] <= idx_next;
                        end
                    end
                    psgrf_pkg::REG_NOISE:    noise_reg[ch]   <= write_data;
                    psgrf_pkg::REG_LFO_FREQ: lfo_freq_reg    <= write_data;
                    psgrf_pkg::REG_LFO_CTRL: lfo_ctrl_reg    <= write_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // wave RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wave_we)
        begin
            wave_mem[ch][wr_idx] <= write_data[psgrf_pkg::SAMPLE_W-1:0];
        end
        if (cmd.rd)
        begin
            wave_rd_reg  <= wave_mem[ch][cur_idx];
            wave_hit_reg <= wave_vld_reg[ch][cur_idx];
        end
    end

    always_comb
    begin
        rd_value = NO_DATA;
        if (reg_addr == psgrf_pkg::REG_CHSEL)
        begin
            rd_value = {{(psgrf_pkg::DATA_W - psgrf_pkg::CHSEL_W){1'b0}}, chsel_reg};
        end
        else if (ch_ok)
        begin
            case (reg_addr)
                psgrf_pkg::REG_VOLUME:   rd_value = volume_reg;
                psgrf_pkg::REG_FREQ_LO:  rd_value = freq_lo_reg[ch];
                psgrf_pkg::REG_FREQ_HI:
                    rd_value = {{(psgrf_pkg::DATA_W - psgrf_pkg::FREQ_HI_W){1'b0}},
                                freq_hi_reg[ch]};
                psgrf_pkg::REG_CONTROL:  rd_value = ctrl_reg[ch];
                psgrf_pkg::REG_BALANCE:  rd_value = balance_reg[ch];
                psgrf_pkg::REG_NOISE:    rd_value = noise_reg[ch];
                psgrf_pkg::REG_LFO_FREQ: rd_value = lfo_freq_reg;
                psgrf_pkg::REG_LFO_CTRL: rd_value = lfo_ctrl_reg;
                default:                 rd_value = NO_DATA;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_mux_reg   <= rd_value;
            sel_wave_reg <= ch_ok && (reg_addr == psgrf_pkg::REG_WAVE);
        end
    end

    // never-written wave entries read as zero
    always_comb
    begin
        if (sel_wave_reg)
        begin
            read_data = wave_hit_reg
                ? {{(psgrf_pkg::DATA_W - psgrf_pkg::SAMPLE_W){1'b0}}, wave_rd_reg}
                : '0;
        end
        else
        begin
            read_data = rd_mux_reg;
        end
    end

endmodule

// File: rtl/psg_register_file_wave_ram_unit.sv
// Top level of the sound generator register file with per-channel wave RAM.
// Depends on psgrf_pkg, psgrf_ctrl, psgrf_datapath and assert_macros.svh.
//
// An item is taken when start is high and busy is low. A write completes in
// the cycle it is accepted and a new item may be started in the next cycle.
// For a read, the wave RAM read port and the register mux are
// captured at the accept edge, and the result is on read_data with done high
// for exactly the following cycle, during which busy is high. The receiver
// cannot stall; done is a one-cycle strobe. The wave RAM needs no clearing
// pass after reset: a valid bit per entry makes unwritten samples read as 0.
module psg_register_file_wave_ram_unit #(
    parameter int NUM_CHANNELS  = 6,
    parameter int WAVE_DEPTH    = 32,
    parameter int NO_DATA_VALUE = 255
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         req_type,
    input  logic [psgrf_pkg::ADDR_W-1:0] reg_addr,
    input  logic [psgrf_pkg::DATA_W-1:0] write_data,
    output logic                         done,
    output logic [psgrf_pkg::DATA_W-1:0] read_data
);

    `include "assert_macros.svh"

    psgrf_pkg::cmd_t cmd;

    psgrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    psgrf_datapath #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .WAVE_DEPTH    (WAVE_DEPTH),
        .NO_DATA_VALUE (NO_DATA_VALUE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .reg_addr   (reg_addr),
        .write_data (write_data),
        .read_data  (read_data)
    );

    `ASSERT_CLK(a_read_responds, clk, rst_n, (start && !busy && !req_type) |=> done)
    `ASSERT_CLK(a_write_silent, clk, rst_n, (start && !busy && req_type) |=> !done)
    `ASSERT_CLK(a_done_single, clk, rst_n, done |=> !done)
    `ASSERT_NEVER(a_cmd_exclusive, clk, rst_n, cmd.wr && cmd.rd)

endmodule

// File: tb/psgrf_readback_checker.sv
// Checker for the sound generator register file: tracks register and wave RAM
// contents from accepted items and compares every read result in order.
// Depends on psgrf_pkg.
module psgrf_readback_checker #(
    parameter int NUM_CH   = 6,
    parameter int WAVE_LEN = 32,
    parameter int NO_DATA  = 255
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         req_type,
    input  logic [psgrf_pkg::ADDR_W-1:0] reg_addr,
    input  logic [psgrf_pkg::DATA_W-1:0] write_data,
    input  logic                         done,
    input  logic [psgrf_pkg::DATA_W-1:0] read_data,
    output int                           errors,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import psgrf_pkg::*;

    logic [CHSEL_W-1:0]   chan_sel;
    logic [DATA_W-1:0]    volume;
    logic [DATA_W-1:0]    lfo_freq;
    logic [DATA_W-1:0]    lfo_ctrl;
    logic [DATA_W-1:0]    freq_lo   [NUM_CH];
    logic [FREQ_HI_W-1:0] freq_hi   [NUM_CH];
    logic [DATA_W-1:0]    control   [NUM_CH];
    logic [DATA_W-1:0]    balance   [NUM_CH];
    logic [DATA_W-1:0]    noise     [NUM_CH];
    int                   wave_ptr  [NUM_CH];
    logic [SAMPLE_W-1:0]  wave_mem  [NUM_CH][WAVE_LEN];

    logic [DATA_W-1:0]    expected_reads[$];
    logic [DATA_W-1:0]    want;
    logic [DATA_W-1:0]    rd_value;
    bit                   is_read;

    initial errors = 0;

    task automatic clear_regfile();
        chan_sel = '0;
        volume   = '0;
        lfo_freq = '0;
        lfo_ctrl = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            freq_lo[c]  = '0;
            freq_hi[c]  = '0;
            control[c]  = CTRL_RESET;
            balance[c]  = '0;
            noise[c]    = '0;
            wave_ptr[c] = 0;
            for (int i = 0; i < WAVE_LEN; i++)
                wave_mem[c][i] = '0;
        end
    endtask

    // Applies one item to the tracked state; reads return the expected byte.
    task automatic regfile_access(input logic wr, input logic [ADDR_W-1:0] a,
                                  input logic [DATA_W-1:0] d,
                                  output bit rd, output logic [DATA_W-1:0] q);
        int ch;
        int idx;
        ch = chan_sel;
        rd = !wr;
        q  = NO_DATA[DATA_W-1:0];
        if (wr)
        begin
            if (a == REG_CHSEL)
                chan_sel = d[CHSEL_W-1:0];
            else if (ch < NUM_CH)
            begin
                case (a)
                    REG_VOLUME:   volume      = d;
                    REG_FREQ_LO:  freq_lo[ch] = d;
                    REG_FREQ_HI:  freq_hi[ch] = d[FREQ_HI_W-1:0];
                    REG_CONTROL:  control[ch] = d;
                    REG_BALANCE:  balance[ch] = d;
                    REG_NOISE:    noise[ch]   = d;
                    REG_LFO_FREQ: lfo_freq    = d;
                    REG_LFO_CTRL: lfo_ctrl    = d;
                    REG_WAVE:
                    begin
                        if (control[ch][CTRL_DIRECT_BIT])
                            wave_mem[ch][0] = d[SAMPLE_W-1:0];
                        else
                        begin
                            idx = wave_ptr[ch];
                            wave_mem[ch][idx] = d[SAMPLE_W-1:0];
                            wave_ptr[ch] = (idx == WAVE_LEN - 1) ? 0 : idx + 1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        else if (a == REG_CHSEL)
            q = DATA_W'(chan_sel);
        else if (ch < NUM_CH)
        begin
            case (a)
                REG_VOLUME:   q = volume;
                REG_FREQ_LO:  q = freq_lo[ch];
                REG_FREQ_HI:  q = DATA_W'(freq_hi[ch]);
                REG_CONTROL:  q = control[ch];
                REG_BALANCE:  q = balance[ch];
                REG_WAVE:     q = DATA_W'(wave_mem[ch][wave_ptr[ch]]);
                REG_NOISE:    q = noise[ch];
                REG_LFO_FREQ: q = lfo_freq;
                REG_LFO_CTRL: q = lfo_ctrl;
                default:      q = NO_DATA[DATA_W-1:0];
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_regfile();
            expected_reads.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_reads.size() == 0)
                begin
                    errors++;
                    $display("%0t: read_data with no read pending, expected none, got %02h",
                             $time, read_data);
                end
                else
                begin
                    want = expected_reads.pop_front();
                    if (read_data !== want)
                    begin
                        errors++;
                        $display("%0t: read_data mismatch, expected %02h, got %02h",
                                 $time, want, read_data);
                    end
                end
            end
            if (start && !busy)
            begin
                regfile_access(req_type, reg_addr, write_data, is_read, rd_value);
                if (is_read)
                    expected_reads.push_back(rd_value);
            end
            pending <= expected_reads.size();
        end
    end

endmodule

// File: tb/tb_psg_register_file_wave_ram_unit.sv
// Testbench top for psg_register_file_wave_ram_unit: drives directed and
// random register/wave RAM accesses. Depends on psgrf_pkg and psgrf_readback_checker.
module tb_psg_register_file_wave_ram_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import psgrf_pkg::*;

    localparam int   NUM_CH      = 6;
    localparam int   WAVE_LEN    = 32;
    localparam int   NO_DATA     = 255;
    localparam int   TOTAL_ITEMS = 540;
    localparam int   CALM_TAIL   = 60;
    localparam logic REQ_READ    = 1'b0;
    localparam logic REQ_WRITE   = 1'b1;
    localparam logic [ADDR_W-1:0] FIRST_UNUSED = REG_LFO_CTRL + 1'b1;
    localparam logic [ADDR_W-1:0] LAST_UNUSED  = '1;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              req_type;
    logic [ADDR_W-1:0] reg_addr;
    logic [DATA_W-1:0] write_data;
    logic              done;
    logic [DATA_W-1:0] read_data;
    int                errors;
    int                pending;

    int                items_sent;
    bit                gaps_on;

    psg_register_file_wave_ram_unit #(
        .NUM_CHANNELS (NUM_CH),
        .WAVE_DEPTH   (WAVE_LEN),
        .NO_DATA_VALUE(NO_DATA)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .reg_addr  (reg_addr),
        .write_data(write_data),
        .done      (done),
        .read_data (read_data)
    );

    psgrf_readback_checker #(
        .NUM_CH  (NUM_CH),
        .WAVE_LEN(WAVE_LEN),
        .NO_DATA (NO_DATA)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .reg_addr  (reg_addr),
        .write_data(write_data),
        .done      (done),
        .read_data (read_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Idle with junk on the fields; start is low so nothing is taken.
    task automatic idle(input int n);
        start <= 1'b0;
        req_type   <= 1'($urandom);
        reg_addr   <= ADDR_W'($urandom);
        write_data <= DATA_W'($urandom);
        repeat (n) @(posedge clk);
    endtask

    task automatic issue(input logic wr, input logic [ADDR_W-1:0] a,
                         input logic [DATA_W-1:0] d);
        start      <= 1'b1;
        req_type   <= wr;
        reg_addr   <= a;
        write_data <= d;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (gaps_on && items_sent < TOTAL_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
            idle($urandom_range(1, 12));
    endtask

    // Hold off until every pending read has come back.
    task automatic drain();
        idle(1);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic select_chan(input int ch);
        logic [DATA_W-1:0] d;
        d = DATA_W'($urandom);
        d[CHSEL_W-1:0] = CHSEL_W'(ch);
        issue(REQ_WRITE, REG_CHSEL, d);
    endtask

    initial
    begin
        logic [DATA_W-1:0] d;
        logic [ADDR_W-1:0] a;
        int                n;
        bit                drained;

        rst_n      <= 1'b0;
        start      <= 1'b0;
        req_type   <= REQ_READ;
        reg_addr   <= '0;
        write_data <= '0;
        items_sent = 0;
        gaps_on    = 1'b0;
        drained    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values
        issue(REQ_READ,  REG_CHSEL,    8'h00);
        issue(REQ_READ,  REG_CONTROL,  8'h00);
        issue(REQ_READ,  REG_WAVE,     8'h00);
        issue(REQ_READ,  LAST_UNUSED,  8'h00);
        // frequency high keeps four bits
        issue(REQ_WRITE, REG_FREQ_HI,  8'hFF);
        issue(REQ_READ,  REG_FREQ_HI,  8'h00);
        issue(REQ_WRITE, REG_VOLUME,   8'hFF);
        issue(REQ_READ,  REG_VOLUME,   8'h00);
        // auto-increment: read sees the next, still empty entry
        issue(REQ_WRITE, REG_WAVE,     8'hFF);
        issue(REQ_READ,  REG_WAVE,     8'h00);
        // direct mode lands on entry 0 and leaves the index alone
        issue(REQ_WRITE, REG_CONTROL,  8'h40);
        issue(REQ_WRITE, REG_WAVE,     8'h0A);
        issue(REQ_READ,  REG_WAVE,     8'h00);
        issue(REQ_WRITE, FIRST_UNUSED + 2'd2, 8'h55);
        issue(REQ_READ,  FIRST_UNUSED + 2'd2, 8'h00);
        // invalid channels: only channel select is live; then back to the last valid channel
        issue(REQ_WRITE, REG_CHSEL,    8'hFF);
        issue(REQ_READ,  REG_CHSEL,    8'h00);
        issue(REQ_WRITE, REG_VOLUME,   8'h00);
        issue(REQ_READ,  REG_VOLUME,   8'h00);
        select_chan(NUM_CH);
        issue(REQ_READ,  REG_NOISE,    8'h00);
        select_chan(NUM_CH - 1);
        issue(REQ_WRITE, REG_LFO_FREQ, 8'h00);
        issue(REQ_READ,  REG_VOLUME,   8'h00);
        issue(REQ_READ,  REG_LFO_CTRL, 8'h00);

        while (items_sent < TOTAL_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 2) != 0);
            if (!drained && items_sent >= TOTAL_ITEMS / 2)
            begin
                drain();
                drained = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: issue(1'($urandom), ADDR_W'($urandom), DATA_W'($urandom));
                1:
                begin
                    select_chan($urandom_range(NUM_CH, 7));
                    repeat ($urandom_range(1, 4))
                        issue(1'($urandom), ADDR_W'($urandom), DATA_W'($urandom));
                end
                2, 3:
                begin
                    select_chan($urandom_range(0, NUM_CH - 1));
                    if ($urandom_range(0, 1) == 0)
                    begin
                        d = DATA_W'($urandom);
                        if ($urandom_range(0, 3) != 0)
                            d[CTRL_DIRECT_BIT] = 1'b0;
                        issue(REQ_WRITE, REG_CONTROL, d);
                    end
                    n = $urandom_range(1, 40);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            issue(REQ_READ, REG_WAVE, DATA_W'($urandom));
                        else
                            issue(REQ_WRITE, REG_WAVE, DATA_W'($urandom));
                    end
                end
                default:
                begin
                    select_chan($urandom_range(0, NUM_CH - 1));
                    repeat ($urandom_range(2, 8))
                    begin
                        a = ADDR_W'($urandom_range(REG_VOLUME, REG_LFO_CTRL));
                        issue(1'($urandom), a, DATA_W'($urandom));
                    end
                end
            endcase
        end

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("tb_psg_register_file_wave_ram_unit: done, clean");
        else
            $display("tb_psg_register_file_wave_ram_unit: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_psg_register_file_wave_ram_unit: done, errors");
        $finish;
    end

endmodule
